[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BBA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bitmap allocator assertion failed");

// Check that a condition is followed in the next cycle by another.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap allocator sequence check failed");

`endif

[design/bba_pkg.sv]
`timescale 1ns / 1ps
package bba_pkg;

  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int STAT_W = 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;

  localparam logic REG_BLOCK_COUNT = 1'b0;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

[design/bba_if.sv]
`timescale 1ns / 1ps
interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, mode, block_index, input ready);
  modport sink   (input valid, mode, block_index, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  granted_index;

  modport source (output valid, status, granted_index, input ready);
  modport sink   (input valid, status, granted_index, output ready);
endinterface

[design/bba_ram.sv]
`timescale 1ns / 1ps
module bba_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/bba_cfg.sv]
`timescale 1ns / 1ps
module bba_cfg import bba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CNT_W-1:0]      block_count
);

  logic [CNT_W-1:0] block_count_r;
  logic             sel_count;

  assign sel_count = (paddr[APB_ADDR_W-1] == REG_BLOCK_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= BLOCK_COUNT_RST;
    end else if (psel && penable && pwrite && sel_count) begin
      block_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready      = 1'b1;
  assign prdata      = sel_count ? APB_DATA_W'(block_count_r) : '0;
  assign block_count = block_count_r;

endmodule

[design/bba_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bba_ctrl import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32,
  parameter int NUM_WORDS  = 128,
  parameter int WA_W       = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bba_req_if.sink              in_req,
  bba_rsp_if.source            out_rsp,
  input  logic [CNT_W-1:0]     block_count,
  output logic                 mem_we,
  output logic [WA_W-1:0]      mem_waddr,
  output logic [WORD_BITS-1:0] mem_wdata,
  output logic                 mem_re,
  output logic [WA_W-1:0]      mem_raddr,
  input  logic [WORD_BITS-1:0] mem_rdata
);

  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int GI_W  = WA_W + BIT_W;
  localparam int MB_W  = $clog2(MAX_BLOCKS + 1);
  localparam int N_W   = (MB_W > CNT_W) ? MB_W : CNT_W;
  localparam int CMP_W = ((GI_W > N_W) ? GI_W : N_W) + 1;
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NUM_WORDS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_POST  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [WA_W-1:0]    word_r, word_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_grant_r, res_grant_nxt;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [IDX_W-1:0]   out_grant_r;

  logic [CMP_W-1:0]     n_eff;
  logic [CMP_W-1:0]     idx_ext;
  logic                 idx_ok;
  logic [WA_W-1:0]      idx_word;
  logic [BIT_W-1:0]     idx_bit;
  logic [CMP_W-1:0]     base;
  logic [CMP_W-1:0]     remaining;
  logic [CMP_W-1:0]     next_base;
  logic [WORD_BITS-1:0] vmask;
  logic [WORD_BITS-1:0] free_vec;
  logic [BIT_W-1:0]     pos;
  logic [CMP_W-1:0]     gidx;
  logic                 slot_free;

  assign n_eff = (CMP_W'(block_count) > CMP_W'(MAX_BLOCKS)) ?
                 CMP_W'(MAX_BLOCKS) : CMP_W'(block_count);

  assign idx_ext  = CMP_W'(in_req.block_index);
  assign idx_ok   = (idx_ext < n_eff);
  assign idx_word = idx_ext[BIT_W +: WA_W];
  assign idx_bit  = idx_ext[BIT_W-1:0];

  assign base      = CMP_W'({word_r, {BIT_W{1'b0}}});
  assign remaining = n_eff - base;
  assign next_base = base + CMP_W'(WORD_BITS);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      vmask[b] = (CMP_W'(b) < remaining);
    end
  end

  assign free_vec = vmask & ~mem_rdata;

  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        pos = BIT_W'(b);
      end
    end
  end

  assign gidx      = CMP_W'({word_r, pos});
  assign slot_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt      = state_r;
    word_nxt       = word_r;
    bit_nxt        = bit_r;
    res_status_nxt = res_status_r;
    res_grant_nxt  = res_grant_r;
    mem_we         = 1'b0;
    mem_waddr      = word_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = word_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (word_r == LAST_WORD) begin
          word_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          word_nxt = word_r + WA_W'(1);
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          if (in_req.mode == MODE_ALLOC) begin
            if (n_eff == '0) begin
              res_status_nxt = ST_FULL;
              res_grant_nxt  = '0;
              state_nxt      = S_POST;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              word_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end else if (idx_ok) begin
            mem_re    = 1'b1;
            mem_raddr = idx_word;
            word_nxt  = idx_word;
            bit_nxt   = idx_bit;
            state_nxt = S_FREE;
          end else begin
            res_status_nxt = ST_RANGE;
            res_grant_nxt  = '0;
            state_nxt      = S_POST;
          end
        end
      end
      S_SCAN: begin
        if (|free_vec) begin
          mem_we         = 1'b1;
          mem_wdata      = mem_rdata | (WORD_BITS'(1) << pos);
          res_status_nxt = ST_OK;
          res_grant_nxt  = IDX_W'({word_r, pos});
          state_nxt      = S_POST;
        end else if (word_r == LAST_WORD || next_base >= n_eff) begin
          res_status_nxt = ST_FULL;
          res_grant_nxt  = '0;
          state_nxt      = S_POST;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = word_r + WA_W'(1);
          word_nxt  = word_r + WA_W'(1);
        end
      end
      S_FREE: begin
        mem_we         = 1'b1;
        mem_wdata      = mem_rdata & ~(WORD_BITS'(1) << bit_r);
        res_status_nxt = ST_OK;
        res_grant_nxt  = '0;
        state_nxt      = S_POST;
      end
      S_POST: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      word_r  <= word_nxt;
      if (state_r == S_POST && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bit_r        <= bit_nxt;
    res_status_r <= res_status_nxt;
    res_grant_r  <= res_grant_nxt;
    if (state_r == S_POST && slot_free) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
    end
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.granted_index = out_grant_r;

  `BBA_ASSERT(a_scan_sets_new_bit, clk, rst_n, (state_r == S_SCAN && mem_we) |-> (mem_wdata != mem_rdata))
  `BBA_ASSERT(a_grant_below_count, clk, rst_n, (state_r == S_SCAN && mem_we) |-> (gidx < n_eff))
  `BBA_ASSERT_NEXT(a_range_reject, clk, rst_n, (in_req.valid && in_req.ready && in_req.mode == MODE_FREE && !idx_ok), (state_r == S_POST && res_status_r == ST_RANGE))

endmodule

[design/bitmap_block_allocator.sv]
`timescale 1ns / 1ps
// First-fit block allocator over a used/free bitmap of MAX_BLOCKS bits, held as
// MAX_BLOCKS/WORD_BITS words (WORD_BITS a power of two) in a single-port-write,
// registered-read RAM. One request is handled at a time. An allocate reads one
// bitmap word per cycle from word 0 and scans at most ceil(min(block_count,
// MAX_BLOCKS)/WORD_BITS) words, 128 with the default sizes; a free reads the
// addressed word and writes it back with the bit cleared; an out-of-range free
// or an allocate with a block count of zero goes straight to its result. The result
// register frees the bitmap side while a response waits. After reset the bitmap is
// cleared one word per cycle over all NUM_WORDS words (128 by default); requests are
// held off until it ends, while block_count writes are taken throughout.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bba_req_if.sink               in_req,
  bba_rsp_if.source             out_rsp,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [CNT_W-1:0]     block_count;
  logic                 mem_we;
  logic [WA_W-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WA_W-1:0]      mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  bba_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .block_count (block_count)
  );

  bba_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (WA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS),
    .NUM_WORDS  (NUM_WORDS),
    .WA_W       (WA_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .out_rsp     (out_rsp),
    .block_count (block_count),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

endmodule
